FILE: design/ckmx_pkg.sv
// shared constants, types and helpers for the checksum matrix corrector
// no dependencies; imported by every module of the block
package ckmx_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int IX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int IDX_W    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int SIZE_W   = 5;
  localparam int TOT_W    = 2 * SIZE_W;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W  = 80;

  localparam logic [SIZE_W-1:0] MAX_ROWS_S = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] MAX_COLS_S = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);

  typedef enum logic [1:0] {
    ST_FIXED    = 2'd0,
    ST_NONE     = 2'd1,
    ST_DISAGREE = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CK_IDLE,
    CK_COLS,
    CK_ROWS,
    CK_DRAIN,
    CK_LOCATE,
    CK_FIX,
    CK_EMIT
  } ck_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    status_t           status;
    logic [SIZE_W-1:0] error_row;
    logic [SIZE_W-1:0] error_col;
    logic [DATA_W-1:0] correction;
    logic [DATA_W-1:0] cell_value;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > max) r = max;
    else r = v;
    return r;
  endfunction

endpackage

FILE: design/ckmx_mem.sv
// matrix store: one write port, one registered read port
// depends on ckmx_pkg
module ckmx_mem (
  input  logic                    clk,
  input  ckmx_pkg::mem_wr_t       wr,
  input  logic [ckmx_pkg::ADDR_W-1:0] rd_addr,
  output logic [ckmx_pkg::DATA_W-1:0] rd_data
);
  import ckmx_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/ckmx_load.sv
// load side: places incoming items in row-major order and flags a full matrix
// depends on ckmx_pkg; re-derives row and column after a size change
module ckmx_load (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ckmx_pkg::SIZE_W-1:0] nr,
  input  logic [ckmx_pkg::SIZE_W-1:0] nc,
  input  logic                        cfg_we,
  input  logic                        scan_idle,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ckmx_pkg::DATA_W-1:0] s_tdata,
  output ckmx_pkg::mem_wr_t           wr,
  output logic                        load_done
);
  import ckmx_pkg::*;

  logic [IDX_W-1:0] load_index;
  logic [ROW_W-1:0] lrow;
  logic [COL_W-1:0] lcol;
  logic             resync;
  logic [IDX_W-1:0] rem;
  logic [ROW_W-1:0] srow;

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] idx_inc;
  logic             fire;

  assign total     = TOT_W'(nr) * TOT_W'(nc);
  assign idx_inc   = TOT_W'(load_index) + TOT_W'(1);
  assign s_tready  = !resync && !cfg_we && scan_idle;
  assign fire      = s_tvalid && s_tready;
  assign load_done = fire && (idx_inc == total);

  assign wr.we   = fire;
  assign wr.addr = {lrow, lcol};
  assign wr.data = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      lrow       <= '0;
      lcol       <= '0;
      resync     <= 1'b0;
    end else if (cfg_we) begin
      resync <= 1'b1;
      rem    <= load_index;
      srow   <= '0;
    end else if (resync) begin
      // restart the count if the new size is already filled, else divide by nc
      if (TOT_W'(load_index) >= total) begin
        load_index <= '0;
        lrow       <= '0;
        lcol       <= '0;
        resync     <= 1'b0;
      end else if (TOT_W'(rem) >= TOT_W'(nc)) begin
        rem  <= rem - IDX_W'(nc);
        srow <= srow + ROW_W'(1);
      end else begin
        lrow   <= srow;
        lcol   <= COL_W'(rem);
        resync <= 1'b0;
      end
    end else if (fire) begin
      if (load_done) begin
        load_index <= '0;
        lrow       <= '0;
        lcol       <= '0;
      end else begin
        load_index <= load_index + IDX_W'(1);
        if (SIZE_W'(lcol) + SIZE_W'(1) == nc) begin
          lcol <= '0;
          lrow <= lrow + ROW_W'(1);
        end else begin
          lcol <= lcol + COL_W'(1);
        end
      end
    end
  end

endmodule

FILE: design/ckmx_scan.sv
// check sequencer: sweeps columns then rows through one shared adder,
// locates the faulty cell and writes back the correction; depends on ckmx_pkg
module ckmx_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ckmx_pkg::SIZE_W-1:0]     nr,
  input  logic [ckmx_pkg::SIZE_W-1:0]     nc,
  input  logic                            start,
  output logic                            idle,
  output logic [ckmx_pkg::ADDR_W-1:0]     rd_addr,
  input  logic [ckmx_pkg::DATA_W-1:0]     rd_data,
  output ckmx_pkg::mem_wr_t               wr,
  output logic                            res_valid,
  input  logic                            res_take,
  output ckmx_pkg::result_t               res
);
  import ckmx_pkg::*;

  ck_state_t state, state_next;

  logic [IX_W-1:0]   maj;
  logic [IX_W-1:0]   mnr;
  logic              p_valid;
  logic              p_last;
  logic              p_rowpass;
  logic [IX_W-1:0]   p_maj;
  logic [DATA_W-1:0] acc;
  logic [SIZE_W-1:0] err_r;
  logic [SIZE_W-1:0] err_c;
  logic [DATA_W-1:0] col_delta;
  logic [DATA_W-1:0] row_delta;

  logic [SIZE_W-1:0] mnr_lim;
  logic [SIZE_W-1:0] maj_lim;
  logic              mnr_end;
  logic              pass_end;
  logic              issue;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic              op_sub;
  logic [DATA_W-1:0] sum;
  logic              agree;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;

  assign mnr_lim  = (state == CK_ROWS) ? nc - SIZE_W'(1) : nr - SIZE_W'(1);
  assign maj_lim  = (state == CK_ROWS) ? nr - SIZE_W'(1) : nc - SIZE_W'(1);
  assign mnr_end  = SIZE_W'(mnr) == mnr_lim;
  assign pass_end = mnr_end && (SIZE_W'(maj) == maj_lim);
  assign issue    = (state == CK_COLS) || (state == CK_ROWS);
  assign cell_row = ROW_W'(err_r - SIZE_W'(1));
  assign cell_col = COL_W'(err_c - SIZE_W'(1));
  assign agree    = col_delta == row_delta;
  assign idle     = state == CK_IDLE;
  assign res_valid = state == CK_EMIT;

  always_comb begin
    unique case (state)
      CK_COLS: rd_addr = {ROW_W'(mnr), COL_W'(maj)};
      CK_ROWS: rd_addr = {ROW_W'(maj), COL_W'(mnr)};
      default: rd_addr = {cell_row, cell_col};
    endcase
  end

  // shared adder: accumulate, checksum minus sum, or cell plus delta
  always_comb begin
    if (state == CK_FIX) begin
      op_a   = rd_data;
      op_b   = col_delta;
      op_sub = 1'b0;
    end else if (p_last) begin
      op_a   = rd_data;
      op_b   = acc;
      op_sub = 1'b1;
    end else begin
      op_a   = acc;
      op_b   = rd_data;
      op_sub = 1'b0;
    end
    sum = op_a + (op_sub ? ~op_b : op_b) + DATA_W'(op_sub);
  end

  assign wr.we   = (state == CK_FIX) && agree;
  assign wr.addr = {cell_row, cell_col};
  assign wr.data = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CK_IDLE:   if (start) state_next = CK_COLS;
      CK_COLS:   if (pass_end) state_next = CK_ROWS;
      CK_ROWS:   if (pass_end) state_next = CK_DRAIN;
      CK_DRAIN:  state_next = CK_LOCATE;
      CK_LOCATE: begin
        if (err_r == '0 || err_c == '0) state_next = CK_EMIT;
        else state_next = CK_FIX;
      end
      CK_FIX:    state_next = CK_EMIT;
      CK_EMIT:   if (res_take) state_next = CK_IDLE;
      default:   state_next = CK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= issue;
      p_last  <= issue && mnr_end;
    end
  end

  always_ff @(posedge clk) begin
    p_maj     <= maj;
    p_rowpass <= state == CK_ROWS;

    if (state == CK_IDLE && start) begin
      maj   <= '0;
      mnr   <= '0;
      acc   <= '0;
      err_r <= '0;
      err_c <= '0;
    end

    if (issue) begin
      if (mnr_end) begin
        mnr <= '0;
        maj <= (SIZE_W'(maj) == maj_lim) ? '0 : maj + IX_W'(1);
      end else begin
        mnr <= mnr + IX_W'(1);
      end
    end

    if (p_valid) begin
      if (p_last) begin
        acc <= '0;
        if (sum != '0) begin
          if (p_rowpass) begin
            err_r     <= SIZE_W'(p_maj) + SIZE_W'(1);
            row_delta <= sum;
          end else begin
            err_c     <= SIZE_W'(p_maj) + SIZE_W'(1);
            col_delta <= sum;
          end
        end
      end else begin
        acc <= sum;
      end
    end

    if (state == CK_LOCATE) begin
      res.status     <= ST_NONE;
      res.error_row  <= err_r;
      res.error_col  <= err_c;
      res.correction <= '0;
      res.cell_value <= '0;
    end

    if (state == CK_FIX) begin
      res.correction <= col_delta;
      if (agree) begin
        res.cell_value <= sum;
        res.status     <= (sum == '0) ? ST_ZERO : ST_FIXED;
      end else begin
        res.cell_value <= rd_data;
        res.status     <= (rd_data == '0) ? ST_ZERO : ST_DISAGREE;
      end
    end
  end

endmodule

FILE: design/checksum_matrix_error_correct.sv
// checksum matrix single-error corrector: load takes one item per cycle while
// no size write, re-indexing or check is in progress; a matrix of nr x nc items
// is checked with one registered read of the store per cycle, twice over, and the
// block takes no further item until that result enters the output register.
// a size write re-indexes the load position before the next item is taken.
// synchronous reset: sizes 16 x 16, load count zero; store contents undefined.
module checksum_matrix_error_correct (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ckmx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckmx_pkg::SIZE_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] element_value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] error_row, [9:5] error_col, [41:10] correction,
  // [73:42] cell_value, [79:74] zero
  output logic [ckmx_pkg::TDATA_W-1:0]    m_tdata,
  output logic [1:0]                      m_tuser    // [1:0] status
);
  import ckmx_pkg::*;

  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;
  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nc;

  mem_wr_t           load_wr;
  mem_wr_t           scan_wr;
  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              load_done;
  logic              scan_idle;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  result_t           out_res;
  logic              out_valid;

  assign nr = clamp_size(rows_in_use, MAX_ROWS_S);
  assign nc = clamp_size(cols_in_use, MAX_COLS_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign mem_wr = scan_wr.we ? scan_wr : load_wr;

  ckmx_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ckmx_load u_load (
    .clk       (clk),
    .rst       (rst),
    .nr        (nr),
    .nc        (nc),
    .cfg_we    (cfg_we),
    .scan_idle (scan_idle),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .wr        (load_wr),
    .load_done (load_done)
  );

  ckmx_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .nr        (nr),
    .nc        (nc),
    .start     (load_done),
    .idle      (scan_idle),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (scan_wr),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register frees the load side while a result waits
  assign res_take = res_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {6'b0, out_res.cell_value, out_res.correction,
                     out_res.error_col, out_res.error_row};

endmodule

FILE: design/ckmx_props.sv
// port-level checks for the checksum matrix corrector, bound to the top level
// depends on ckmx_pkg
module ckmx_props (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ckmx_pkg::TDATA_W-1:0] m_tdata,
  input logic [1:0]                   m_tuser
);
  import ckmx_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no location found: no correction and no cell reported
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_NONE |-> m_tdata[73:10] == '0)
    else $error("unlocated result carries data");

  // any other status needs both a row and a column, and zero status a zero cell
  a_loc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_NONE |->
      m_tdata[4:0] != '0 && m_tdata[9:5] != '0 &&
      ((m_tuser == ST_ZERO) == (m_tdata[73:42] == '0)))
    else $error("location or zero status inconsistent");

  // a result never follows straight on from an accepted item
  a_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared right after an item");

endmodule

bind checksum_matrix_error_correct ckmx_props u_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/sv/tb_checksum_matrix_error_correct.sv
// testbench for checksum_matrix_error_correct: streams full-checksum matrices,
// predicts the located and repaired cell, and checks every result in order
// depends on ckmx_pkg and the block's top module only
`timescale 1ns / 1ps

module tb_checksum_matrix_error_correct;
  import ckmx_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS   = 1300;
  localparam int DRAIN_WAIT   = 2 * MAX_ROWS * MAX_COLS + 8;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [TDATA_W-1:0]   m_tdata;
  logic [1:0]           m_tuser;

  checksum_matrix_error_correct u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // one 2 x 2 matrix per row, elements in row-major order
  typedef struct packed {
    logic [0:3][31:0] elem;
    logic             typed;
    result_t          res;
  } dir_mx_t;

  dir_mx_t     dir_tab [0:5];

  // predictor state
  logic [31:0] cells [MAX_ROWS][MAX_COLS];
  logic [4:0]  rows_cfg;
  logic [4:0]  cols_cfg;
  int          fill_cnt;
  result_t     pending_results [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_req;
  int          errors;
  int          items_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_checksum_matrix_error_correct: errors");
    $finish;
  end

  function automatic int eff_size(input logic [4:0] raw, input int max);
    if (raw < 5'd2) return 2;
    if (int'(raw) > max) return max;
    return int'(raw);
  endfunction

  function automatic logic [31:0] col_sum(input int c, input int nr);
    logic [31:0] s;
    s = '0;
    for (int r = 0; r < nr - 1; r++) s = s + cells[r][c];
    return s;
  endfunction

  function automatic logic [31:0] row_sum(input int r, input int nc);
    logic [31:0] s;
    s = '0;
    for (int c = 0; c < nc - 1; c++) s = s + cells[r][c];
    return s;
  endfunction

  // last bad row and column locate the cell; agreeing deltas repair it in the store
  task automatic locate_and_fix(input int nr, input int nc, output result_t res);
    int          bad_r;
    int          bad_c;
    logic [31:0] cd;
    logic [31:0] rd;
    logic [31:0] v;
    bad_r = 0;
    bad_c = 0;
    for (int c = 0; c < nc; c++)
      if (cells[nr-1][c] != col_sum(c, nr)) bad_c = c + 1;
    for (int r = 0; r < nr; r++)
      if (cells[r][nc-1] != row_sum(r, nc)) bad_r = r + 1;
    res.error_row = 5'(bad_r);
    res.error_col = 5'(bad_c);
    if (bad_r == 0 || bad_c == 0) begin
      res.status     = ST_NONE;
      res.correction = '0;
      res.cell_value = '0;
    end else begin
      cd = cells[nr-1][bad_c-1] - col_sum(bad_c - 1, nr);
      rd = cells[bad_r-1][nc-1] - row_sum(bad_r - 1, nc);
      v  = cells[bad_r-1][bad_c-1];
      if (cd == rd) begin
        v = v + cd;
        cells[bad_r-1][bad_c-1] = v;
        res.status = ST_FIXED;
      end else begin
        res.status = ST_DISAGREE;
      end
      if (v == '0) res.status = ST_ZERO;
      res.correction = cd;
      res.cell_value = v;
    end
  endtask

  task automatic absorb_element(input logic [31:0] v, input logic typed,
                                input result_t typed_res);
    int      nr;
    int      nc;
    int      total;
    result_t res;
    nr    = eff_size(rows_cfg, MAX_ROWS);
    nc    = eff_size(cols_cfg, MAX_COLS);
    total = nr * nc;
    if (fill_cnt >= total) fill_cnt = 0;
    cells[fill_cnt / nc][fill_cnt % nc] = v;
    fill_cnt++;
    if (fill_cnt == total) begin
      fill_cnt = 0;
      locate_and_fix(nr, nc, res);
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] nonzero_delta();
    logic [31:0] d;
    d = pick_word();
    return (d == '0) ? 32'd1 : d;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_elem(input logic [31:0] v, input logic typed, input result_t typed_res);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    absorb_element(v, typed, typed_res);
    @(negedge clk);
  endtask

  task automatic send_matrix();
    logic [31:0] mx [MAX_ROWS][MAX_COLS];
    logic [31:0] acc;
    int          nr;
    int          nc;
    int          kind;
    int          er;
    int          ec;
    nr   = eff_size(rows_cfg, MAX_ROWS);
    nc   = eff_size(cols_cfg, MAX_COLS);
    kind = $urandom_range(0, 9);
    for (int r = 0; r < nr - 1; r++)
      for (int c = 0; c < nc - 1; c++) mx[r][c] = pick_word();
    er = $urandom_range(0, nr - 2);
    ec = $urandom_range(0, nc - 2);
    // repaired cell comes back as zero
    if (kind == 2) mx[er][ec] = '0;
    for (int r = 0; r < nr - 1; r++) begin
      acc = '0;
      for (int c = 0; c < nc - 1; c++) acc = acc + mx[r][c];
      mx[r][nc-1] = acc;
    end
    // the corner sums the row checksums
    for (int c = 0; c < nc; c++) begin
      acc = '0;
      for (int r = 0; r < nr - 1; r++) acc = acc + mx[r][c];
      mx[nr-1][c] = acc;
    end
    case (kind)
      0, 1, 2, 3: mx[er][ec] = mx[er][ec] + nonzero_delta();
      4: begin
        // a hit that may land on a checksum cell
        er = $urandom_range(0, nr - 1);
        ec = $urandom_range(0, nc - 1);
        mx[er][ec] = mx[er][ec] + nonzero_delta();
      end
      5: ;
      6, 7: begin
        repeat ($urandom_range(2, 3)) begin
          er = $urandom_range(0, nr - 1);
          ec = $urandom_range(0, nc - 1);
          mx[er][ec] = mx[er][ec] + nonzero_delta();
        end
      end
      default: begin
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++) mx[r][c] = pick_word();
      end
    endcase
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) send_elem(mx[r][c], 1'b0, '0);
  endtask

  // stop offering and let the block run dry before touching the sizes
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic set_sizes(input logic [4:0] r, input logic [4:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= r;
    @(negedge clk);
    cfg_index <= REG_COLS;
    cfg_data  <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rows_cfg = r;
    cols_cfg = c;
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = status_t'(m_tuser);
      got.error_row  = m_tdata[4:0];
      got.error_col  = m_tdata[9:5];
      got.correction = m_tdata[41:10];
      got.cell_value = m_tdata[73:42];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: st=%0d row=%0d col=%0d corr=%h cell=%h",
                 $time, got.status, got.error_row, got.error_col, got.correction,
                 got.cell_value);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected st=%0d row=%0d col=%0d corr=%h cell=%h", $time,
                   want.status, want.error_row, want.error_col, want.correction,
                   want.cell_value);
          $display("%0t:   actual st=%0d row=%0d col=%0d corr=%h cell=%h", $time,
                   got.status, got.error_row, got.error_col, got.correction,
                   got.cell_value);
        end
      end
    end
  end

  initial begin : stimulus
    int          base;
    int          phase;
    int          n;
    int          mats;
    logic [4:0]  raw_r;
    logic [4:0]  raw_c;
    bit          calm;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROWS;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b0;
    errors     = 0;
    items_sent = 0;
    rows_cfg   = 5'd16;
    cols_cfg   = 5'd16;
    fill_cnt   = 0;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++) cells[r][c] = '0;

    dir_tab[0] = '{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
                   '{ST_NONE, 5'd0, 5'd0, 32'h0, 32'h0}};
    dir_tab[1] = '{'{32'h5, 32'h0, 32'h0, 32'h0}, 1'b1,
                   '{ST_ZERO, 5'd1, 5'd1, 32'hFFFF_FFFB, 32'h0}};
    dir_tab[2] = '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
                   '{ST_FIXED, 5'd1, 5'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF}};
    // every line off, deltas disagree
    dir_tab[3] = '{'{32'h0, 32'h1, 32'h2, 32'h3}, 1'b0, '0};
    // columns off but every row sums
    dir_tab[4] = '{'{32'h1, 32'h1, 32'h2, 32'h2}, 1'b1,
                   '{ST_NONE, 5'd0, 5'd2, 32'h0, 32'h0}};
    // deltas disagree on a zero cell
    dir_tab[5] = '{'{32'h3, 32'h0, 32'h3, 32'h3}, 1'b1,
                   '{ST_ZERO, 5'd1, 5'd2, 32'h3, 32'h0}};

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sizes straight out of reset
    send_matrix();
    settle();

    set_sizes(5'd2, 5'd2);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 4; k++) send_elem(dir_tab[i].elem[k], dir_tab[i].typed, dir_tab[i].res);

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      case (phase)
        0: begin raw_r = 5'd2;  raw_c = 5'd2;  end
        1: begin raw_r = 5'd16; raw_c = 5'd16; end
        2: begin raw_r = 5'd2;  raw_c = 5'd16; end
        3: begin raw_r = 5'd16; raw_c = 5'd2;  end
        4: begin raw_r = 5'd0;  raw_c = 5'd1;  end
        5: begin raw_r = 5'd31; raw_c = 5'd17; end
        6: begin raw_r = 5'd3;  raw_c = 5'd2;  end
        default: begin
          case ($urandom_range(0, 9))
            0:       raw_r = 5'd16;
            1:       raw_r = $urandom_range(0, 1) ? 5'($urandom_range(17, 31)) : 5'd1;
            default: raw_r = 5'($urandom_range(2, 5));
          endcase
          case ($urandom_range(0, 9))
            0:       raw_c = 5'd16;
            1:       raw_c = $urandom_range(0, 1) ? 5'($urandom_range(17, 31)) : 5'd0;
            default: raw_c = 5'($urandom_range(2, 5));
          endcase
        end
      endcase
      settle();
      set_sizes(raw_r, raw_c);
      calm       = (items_sent - base >= CALM_ITEMS);
      tx_idle_on = !calm && ($urandom_range(0, 3) != 0);
      rx_idle_on = !calm && ($urandom_range(0, 3) != 0);
      // long output hold-off while small matrices keep coming
      if (phase == 6) hold_req = 1'b1;
      n    = eff_size(raw_r, MAX_ROWS) * eff_size(raw_c, MAX_COLS);
      mats = (n >= 120) ? 1 : 120 / n;
      repeat (mats) send_matrix();
      phase++;
    end

    settle();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("tb_checksum_matrix_error_correct: clean");
    end else begin
      $display("tb_checksum_matrix_error_correct: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ckmx_pkg.sv
design/ckmx_mem.sv
design/ckmx_load.sv
design/ckmx_scan.sv
design/checksum_matrix_error_correct.sv
design/ckmx_props.sv
tb/sv/tb_checksum_matrix_error_correct.sv
